[hw/rtl/scis_pkg.sv]
// shared types, constants and helpers for the sign change interval scanner
package scis_pkg;

    // register word indexes on the configuration port
    typedef enum logic [2:0] {
        REG_SCAN_START = 3'd0,
        REG_SCAN_END   = 3'd1,
        REG_STEP_SIZE  = 3'd2,
        REG_ZERO_BAND  = 3'd3,
        REG_CAPACITY   = 3'd4
    } t_reg_idx;

    localparam int unsigned PADDR_W = 5;
    localparam int unsigned COUNT_W = 11;

    // hard limit on the number of reported intervals
    localparam logic [COUNT_W-1:0] MAX_INTERVALS = 11'd1024;

    // register reset values
    localparam logic signed [31:0] RST_SCAN_START = 32'sd0;
    localparam logic signed [31:0] RST_SCAN_END   = 32'sd65536;
    localparam logic [30:0]        RST_STEP_SIZE  = 31'd4096;
    localparam logic [30:0]        RST_ZERO_BAND  = 31'd0;
    localparam logic [COUNT_W-1:0] RST_CAPACITY   = 11'd16;

    // magnitude of a 33 bit signed value
    function automatic logic [32:0] abs_s33(input logic signed [32:0] v);
        logic signed [32:0] neg;
        neg = -v;
        return v[32] ? neg : v;
    endfunction

    // magnitude of a 35 bit signed value
    function automatic logic [34:0] abs_s35(input logic signed [34:0] v);
        logic signed [34:0] neg;
        neg = -v;
        return v[34] ? neg : v;
    endfunction

endpackage

[hw/rtl/sign_change_interval_scanner_top.sv]
// sign change interval scanner: grid scan that brackets roots of a sampled function
//
// Each input beat carries one Q16.16 function sample on a uniform grid that starts at
// scan_start, advances by step_size and is clamped at scan_end; restart marks the sample
// at scan_start. The block takes one beat every cycle unless the result side stalls: the
// sample is registered, the bracket, duplicate and capacity checks run combinationally
// against the stored left point and last report, and the result lands in an output
// register. The stored scan state is loaded along with that register, so back-to-back
// samples never wait on each other; only a stall on the result side holds the input.
// Samples ignored before the first restart or after the scan stops produce no result beat.
// Configuration is an APB-style port with 32 bit words at byte address 4*index.
module sign_change_interval_scanner_top
    import scis_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // sample channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [31:0]        i_sample_value,
    input  logic                      i_restart,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_interval_valid,
    output logic signed [31:0]        o_interval_left,
    output logic signed [31:0]        o_interval_right,
    output logic [COUNT_W-1:0]        o_interval_index,
    output logic                      o_scan_finished,
    output logic                      o_capacity_full,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    // configuration registers
    logic signed [31:0]   r_scan_start;
    logic signed [31:0]   r_scan_end;
    logic [30:0]          r_step_size;
    logic [30:0]          r_zero_band;
    logic [COUNT_W-1:0]   r_capacity;

    // input register
    logic                 r_in_vld;
    logic signed [31:0]   r_in_sample;
    logic                 r_in_restart;

    // scan state
    logic signed [31:0]   r_pos_left, n_pos_left;
    logic signed [31:0]   r_val_left, n_val_left;
    logic                 r_have_left, n_have_left;
    logic signed [31:0]   r_last_left, n_last_left;
    logic signed [31:0]   r_last_right, n_last_right;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic                 r_stopped, n_stopped;

    // result register
    logic                 r_out_vld;
    logic                 r_res_ivalid;
    logic signed [31:0]   r_res_left;
    logic signed [31:0]   r_res_right;
    logic [COUNT_W-1:0]   r_res_index;
    logic                 r_res_fin;
    logic                 r_res_full;

    // combinational result
    logic                 res_emit;
    logic                 res_ivalid;
    logic signed [31:0]   res_left;
    logic signed [31:0]   res_right;
    logic                 res_fin;
    logic                 res_full;

    logic                 advance;
    logic                 cfg_wr;
    logic [2:0]           reg_idx;

    // datapath terms
    logic [30:0]          step_eff;
    logic [COUNT_W-1:0]   cap_eff;
    logic signed [32:0]   xr_sum;
    logic signed [31:0]   xr;
    logic                 left_at_end;
    logic                 left_zero;
    logic                 right_zero;
    logic                 opposite;
    logic                 cand;
    logic signed [31:0]   cl;
    logic signed [31:0]   cr;
    logic                 same_ends;
    logic                 same_zone;
    logic                 dup;
    logic [32:0]          d_left;
    logic [32:0]          d_right;
    logic [32:0]          w_prev;
    logic [32:0]          w_cand;
    logic [34:0]          d_mid;

    // handshake: the compute stage moves when the result register is free or draining
    assign advance     = !r_out_vld || !i_out_stall;
    assign o_in_stall  = r_in_vld && !advance;
    assign o_out_valid = r_out_vld;

    assign o_interval_valid = r_res_ivalid;
    assign o_interval_left  = r_res_left;
    assign o_interval_right = r_res_right;
    assign o_interval_index = r_res_index;
    assign o_scan_finished  = r_res_fin;
    assign o_capacity_full  = r_res_full;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_start <= RST_SCAN_START;
            r_scan_end   <= RST_SCAN_END;
            r_step_size  <= RST_STEP_SIZE;
            r_zero_band  <= RST_ZERO_BAND;
            r_capacity   <= RST_CAPACITY;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SCAN_START: r_scan_start <= pwdata;
                REG_SCAN_END:   r_scan_end   <= pwdata;
                REG_STEP_SIZE:  r_step_size  <= pwdata[30:0];
                REG_ZERO_BAND:  r_zero_band  <= pwdata[30:0];
                REG_CAPACITY:   r_capacity   <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx)
            REG_SCAN_START: prdata = r_scan_start;
            REG_SCAN_END:   prdata = r_scan_end;
            REG_STEP_SIZE:  prdata = {1'b0, r_step_size};
            REG_ZERO_BAND:  prdata = {1'b0, r_zero_band};
            REG_CAPACITY:   prdata = {{(32-COUNT_W){1'b0}}, r_capacity};
            default:        prdata = 32'd0;
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_sample  <= i_sample_value;
            r_in_restart <= i_restart;
        end
    end

    // grid step and right point, clamped to the scan end
    assign step_eff    = (r_step_size == 31'd0) ? 31'd1 : r_step_size;
    assign cap_eff     = (r_capacity < MAX_INTERVALS) ? r_capacity : MAX_INTERVALS;
    assign xr_sum      = $signed({r_pos_left[31], r_pos_left}) + $signed({2'b00, step_eff});
    assign xr          = (xr_sum > $signed({r_scan_end[31], r_scan_end})) ? r_scan_end
                                                                           : xr_sum[31:0];
    assign left_at_end = (r_pos_left >= r_scan_end);

    // bracket candidate
    assign left_zero  = abs_s33({r_val_left[31], r_val_left}) <= {2'b00, r_zero_band};
    assign right_zero = abs_s33({r_in_sample[31], r_in_sample}) <= {2'b00, r_zero_band};
    assign opposite   = (r_val_left[31] && !r_in_sample[31] && (r_in_sample != 32'sd0))
                     || (!r_val_left[31] && (r_val_left != 32'sd0) && r_in_sample[31]);

    always_comb begin
        cand = 1'b1;
        cl   = r_pos_left;
        cr   = r_pos_left;
        priority if (left_zero) begin
            cl = r_pos_left;
            cr = r_pos_left;
        end else if (opposite) begin
            cl = r_pos_left;
            cr = xr;
        end else if (right_zero) begin
            cl = xr;
            cr = xr;
        end else begin
            cand = 1'b0;
        end
    end

    // repeat of the last report: close endpoints, or narrow and close midpoints
    assign d_left  = abs_s33($signed({r_last_left[31], r_last_left}) - $signed({cl[31], cl}));
    assign d_right = abs_s33($signed({r_last_right[31], r_last_right}) - $signed({cr[31], cr}));
    assign w_prev  = abs_s33($signed({r_last_right[31], r_last_right})
                           - $signed({r_last_left[31], r_last_left}));
    assign w_cand  = abs_s33($signed({cr[31], cr}) - $signed({cl[31], cl}));
    assign d_mid   = abs_s35(($signed({{3{r_last_left[31]}}, r_last_left})
                            + $signed({{3{r_last_right[31]}}, r_last_right}))
                           - ($signed({{3{cl[31]}}, cl}) + $signed({{3{cr[31]}}, cr})));
    assign same_ends = (d_left <= {2'b00, r_zero_band}) && (d_right <= {2'b00, r_zero_band});
    assign same_zone = (d_mid <= {4'd0, step_eff}) && (w_prev <= {2'b00, step_eff})
                    && (w_cand <= {2'b00, step_eff});
    assign dup       = (r_count != '0) && (same_ends || same_zone);

    // per-sample scan step
    always_comb begin
        n_pos_left   = r_pos_left;
        n_val_left   = r_val_left;
        n_have_left  = r_have_left;
        n_last_left  = r_last_left;
        n_last_right = r_last_right;
        n_count      = r_count;
        n_stopped    = r_stopped;
        res_emit     = 1'b0;
        res_ivalid   = 1'b0;
        res_left     = 32'sd0;
        res_right    = 32'sd0;
        res_fin      = 1'b0;
        res_full     = 1'b0;
        priority if (r_in_restart) begin
            n_count      = '0;
            n_have_left  = 1'b1;
            n_pos_left   = r_scan_start;
            n_val_left   = r_in_sample;
            n_last_left  = 32'sd0;
            n_last_right = 32'sd0;
            n_stopped    = (r_scan_start >= r_scan_end);
            res_emit     = 1'b1;
            res_fin      = n_stopped;
        end else if (!r_have_left || r_stopped) begin
            res_emit = 1'b0;
        end else if (left_at_end) begin
            n_stopped = 1'b1;
            res_emit  = 1'b1;
            res_fin   = 1'b1;
        end else if (cand && !dup && (r_count >= cap_eff)) begin
            // bracket found with no room left: sample is not consumed
            n_stopped = 1'b1;
            res_emit  = 1'b1;
            res_full  = 1'b1;
        end else begin
            res_emit   = 1'b1;
            n_pos_left = xr;
            n_val_left = r_in_sample;
            n_stopped  = (xr >= r_scan_end);
            res_fin    = n_stopped;
            if (cand && !dup) begin
                n_last_left  = cl;
                n_last_right = cr;
                n_count      = r_count + 1'b1;
                res_ivalid   = 1'b1;
                res_left     = cl;
                res_right    = cr;
            end
        end
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_left   <= 32'sd0;
            r_val_left   <= 32'sd0;
            r_have_left  <= 1'b0;
            r_last_left  <= 32'sd0;
            r_last_right <= 32'sd0;
            r_count      <= '0;
            r_stopped    <= 1'b0;
        end else if (r_in_vld && advance) begin
            r_pos_left   <= n_pos_left;
            r_val_left   <= n_val_left;
            r_have_left  <= n_have_left;
            r_last_left  <= n_last_left;
            r_last_right <= n_last_right;
            r_count      <= n_count;
            r_stopped    <= n_stopped;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld && res_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld && advance && res_emit) begin
            r_res_ivalid <= res_ivalid;
            r_res_left   <= res_left;
            r_res_right  <= res_right;
            r_res_index  <= n_count;
            r_res_fin    <= res_fin;
            r_res_full   <= res_full;
        end
    end

endmodule

[sim/sign_change_interval_scanner_top_tb.sv]
// self-checking testbench for the sign change interval scanner: directed table, then random scans
module sign_change_interval_scanner_top_tb
    import scis_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // one result beat as the block reports it
    typedef struct packed {
        logic               ivalid;
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic [COUNT_W-1:0] index;
        logic               fin;
        logic               full;
    } t_bracket;

    // how a directed row gets its expected result
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_SILENT
    } t_row_kind;

    typedef struct packed {
        logic        rs;
        logic [31:0] val;
        t_row_kind   kind;
        t_bracket    want;
    } t_row;

    // dut ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic signed [31:0]   i_sample_value = '0;
    logic                 i_restart = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_interval_valid;
    logic signed [31:0]   o_interval_left;
    logic signed [31:0]   o_interval_right;
    logic [COUNT_W-1:0]   o_interval_index;
    logic                 o_scan_finished;
    logic                 o_capacity_full;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    sign_change_interval_scanner_top dut (.*);

    // register shadow
    logic signed [31:0]   cfg_start = RST_SCAN_START;
    logic signed [31:0]   cfg_end = RST_SCAN_END;
    logic [30:0]          cfg_step = RST_STEP_SIZE;
    logic [30:0]          cfg_band = RST_ZERO_BAND;
    logic [COUNT_W-1:0]   cfg_cap = RST_CAPACITY;

    // scan state of the predictor
    logic signed [31:0]   left_pos = '0;
    logic signed [31:0]   left_val = '0;
    logic signed [31:0]   prev_l = '0;
    logic signed [31:0]   prev_r = '0;
    bit                   have_left = 1'b0;
    bit                   halted = 1'b0;
    int unsigned          n_found = 0;

    t_bracket             pending_brackets[$];
    t_row                 dir_rows[$];
    bit                   calm = 1'b0;
    bit                   trend_neg = 1'b0;
    int                   n_fail = 0;
    int                   n_live = 0;
    int                   n_sent = 0;
    int                   n_reports = 0;
    int                   n_finished = 0;
    int                   n_full = 0;
    int                   n_phases = 0;
    int                   stall_left = 0;
    int                   stall_roll;
    t_bracket             chk_want;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint mag(input longint a);
        return (a < 0) ? -a : a;
    endfunction

    // next expected beat for one sample, updates the scan state
    function automatic bit predict_bracket(input logic rs, input logic signed [31:0] v,
                                           output t_bracket r);
        longint      band, stp, xl, xr, fl, fr, cl, cr, pl, pr, e;
        int unsigned cap_eff;
        bit          cand, same_ends, same_zone;
        band = cfg_band;
        stp = (cfg_step == '0) ? 1 : cfg_step;
        cap_eff = (cfg_cap < MAX_INTERVALS) ? cfg_cap : MAX_INTERVALS;
        e = cfg_end;
        r = '0;
        cand = 1'b0;
        // restart loads the start point and clears the scan
        if (rs) begin
            n_found = 0;
            halted = 1'b0;
            have_left = 1'b1;
            left_pos = cfg_start;
            left_val = v;
            prev_l = '0;
            prev_r = '0;
            if (cfg_start >= cfg_end) begin
                halted = 1'b1;
                r.fin = 1'b1;
            end
            return 1'b1;
        end
        if (!have_left || halted)
            return 1'b0;
        // left point already at or past the end
        xl = left_pos;
        if (xl >= e) begin
            halted = 1'b1;
            r.fin = 1'b1;
            r.index = COUNT_W'(n_found);
            return 1'b1;
        end
        xr = xl + stp;
        if (xr > e)
            xr = e;
        fl = left_val;
        fr = v;
        cl = 0;
        cr = 0;
        // bracket tests: left zero, strict sign change, right zero
        if (mag(fl) <= band) begin
            cl = xl; cr = xl; cand = 1'b1;
        end else if ((fl < 0 && fr > 0) || (fl > 0 && fr < 0)) begin
            cl = xl; cr = xr; cand = 1'b1;
        end else if (mag(fr) <= band) begin
            cl = xr; cr = xr; cand = 1'b1;
        end
        // repeat of the last report is dropped
        if (cand && n_found > 0) begin
            pl = prev_l;
            pr = prev_r;
            same_ends = mag(pl - cl) <= band && mag(pr - cr) <= band;
            same_zone = mag((pl + pr) - (cl + cr)) <= stp && mag(pr - pl) <= stp &&
                        mag(cr - cl) <= stp;
            if (same_ends || same_zone)
                cand = 1'b0;
        end
        if (cand) begin
            if (n_found >= cap_eff) begin
                halted = 1'b1;
                r.full = 1'b1;
                r.index = COUNT_W'(n_found);
                return 1'b1;
            end
            prev_l = cl[31:0];
            prev_r = cr[31:0];
            n_found++;
        end
        left_pos = xr[31:0];
        left_val = v;
        if (xr >= e)
            halted = 1'b1;
        r.index = COUNT_W'(n_found);
        r.fin = halted;
        if (cand) begin
            r.ivalid = 1'b1;
            r.left = cl[31:0];
            r.right = cr[31:0];
        end
        return 1'b1;
    endfunction

    // sample values that wander in sign and often land inside the zero band
    function automatic logic signed [31:0] make_value();
        int unsigned roll;
        longint      m;
        if ($urandom_range(0, 99) < 30)
            trend_neg = ~trend_neg;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 25) begin
            m = longint'($urandom) % (longint'(cfg_band) + 1);
            return 32'(trend_neg ? -m : m);
        end
        if (roll < 35)
            return $urandom;
        m = $urandom_range(1, 1 << 20);
        return 32'(trend_neg ? -m : m);
    endfunction

    function automatic int pick_gap();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // one sample beat; expectation queued at acceptance
    task automatic send_sample(input logic rs, input logic signed [31:0] v,
                               input t_row_kind kind, input t_bracket want);
        t_bracket got;
        bit       live;
        int       gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_value <= v;
        i_restart <= rs;
        do @(posedge i_clk); while (o_in_stall);
        live = predict_bracket(rs, v, got);
        if (kind == ROW_TYPED)
            pending_brackets.push_back(want);
        else if (kind == ROW_PREDICT && live)
            pending_brackets.push_back(got);
        if (live)
            n_live++;
        n_sent++;
        @(negedge i_clk);
    endtask

    // hold the input until every expected beat is back, then let the pipe empty
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_brackets.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SCAN_START: cfg_start = val;
            REG_SCAN_END:   cfg_end = val;
            REG_STEP_SIZE:  cfg_step = val[30:0];
            REG_ZERO_BAND:  cfg_band = val[30:0];
            REG_CAPACITY:   cfg_cap = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // register settings for one phase; first phases hit the corners
    task automatic setup_phase(input int p);
        logic [31:0] s, e, stp, band, cap;
        longint      e_wide;
        int unsigned roll;
        bit          all;
        s = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            stp = $urandom_range(1, 255);
        else if (roll < 85)
            stp = $urandom_range(256, 65536);
        else if (roll < 95)
            stp = $urandom_range(65537, 1 << 24);
        else
            stp = $urandom & 32'h7fff_ffff;
        e_wide = longint'($signed(s)) + longint'(stp) * $urandom_range(1, 24) -
                 ((stp == 0) ? 0 : $urandom_range(0, stp - 1));
        if (e_wide > 64'sd2147483647)
            e_wide = 64'sd2147483647;
        e = e_wide[31:0];
        roll = $urandom_range(0, 99);
        if (roll < 30)
            band = 0;
        else if (roll < 80)
            band = $urandom_range(0, (stp == 0) ? 1 : stp);
        else if (roll < 90)
            band = $urandom & 32'h7fff_ffff;
        else
            band = $urandom_range(0, 16);
        roll = $urandom_range(0, 99);
        if (roll < 60)
            cap = $urandom_range(0, 6);
        else if (roll < 75)
            cap = 16;
        else if (roll < 85)
            cap = 1024;
        else if (roll < 92)
            cap = 2047;
        else
            cap = $urandom & 32'h7ff;
        all = (p < 8);
        case (p)
            // widest grid, widest band, largest capacity
            0: begin
                s = 32'h8000_0000; e = 32'h7fff_ffff; stp = 32'h7fff_ffff;
                band = 32'h7fff_ffff; cap = 2047;
            end
            // zero step, no capacity at all
            1: begin
                stp = 0; band = 0; cap = 0;
                e_wide = longint'($signed(s)) + 7;
                if (e_wide > 64'sd2147483647)
                    e_wide = 64'sd2147483647;
                e = e_wide[31:0];
            end
            // empty grid: start equal to end
            2: begin
                e = s; cap = 1;
            end
            // empty grid: start above end
            3: begin
                s = 32'h7fff_ffff; e = 32'h8000_0000; stp = 1; band = 0; cap = 1024;
            end
            4: cap = 1;
            // left point pushed past a rewritten end
            5: begin
                s = 0; e = 1 << 20; stp = 4096; cap = 16;
            end
            default: ;
        endcase
        if (all || $urandom_range(0, 1)) write_reg(REG_SCAN_START, s);
        if (all || $urandom_range(0, 1)) write_reg(REG_SCAN_END, e);
        if (all || $urandom_range(0, 1)) write_reg(REG_STEP_SIZE, stp);
        if (all || $urandom_range(0, 1)) write_reg(REG_ZERO_BAND, band);
        write_reg(REG_CAPACITY, cap);
    endtask

    // one restart followed by samples along the grid, with a little noise
    task automatic run_scan();
        longint stp, span, cells;
        int     k;
        stp = (cfg_step == '0) ? 1 : cfg_step;
        span = longint'(cfg_end) - longint'(cfg_start);
        cells = (span > 0) ? (span + stp - 1) / stp : 0;
        if (cells > 40)
            cells = 40;
        if ($urandom_range(0, 9) < 7)
            k = int'(cells) + int'($urandom_range(0, 2));
        else
            k = int'($urandom_range(0, int'(cells)));
        if (k > 40)
            k = 40;
        send_sample(1'b1, make_value(), ROW_PREDICT, '0);
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 39) == 0)
                send_sample(1'b1, make_value(), ROW_PREDICT, '0);
            else
                send_sample(1'b0, make_value(), ROW_PREDICT, '0);
        end
    endtask

    task automatic add_row(input logic rs, input logic [31:0] v, input t_row_kind kind,
                           input t_bracket want);
        t_row row;
        row.rs = rs;
        row.val = v;
        row.kind = kind;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // result side stall pattern
    always @(negedge i_clk) begin
        stall_roll = $urandom_range(0, 99);
        if (calm) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (stall_roll < 70) begin
            i_out_stall <= 1'b0;
        end else if (stall_roll < 95) begin
            stall_left = $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            stall_left = $urandom_range(8, 25);
            i_out_stall <= 1'b1;
        end
    end

    task automatic cmp_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // result beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_brackets.size() == 0) begin
                $error("result beat with no expectation pending");
                n_fail++;
            end else begin
                chk_want = pending_brackets.pop_front();
                cmp_field("interval_valid", chk_want.ivalid, o_interval_valid);
                cmp_field("interval_left", chk_want.left, o_interval_left);
                cmp_field("interval_right", chk_want.right, o_interval_right);
                cmp_field("interval_index", chk_want.index, o_interval_index);
                cmp_field("scan_finished", chk_want.fin, o_scan_finished);
                cmp_field("capacity_full", chk_want.full, o_capacity_full);
            end
            n_reports += o_interval_valid;
            n_finished += o_scan_finished;
            n_full += o_capacity_full;
        end
    end

    // stimulus
    initial begin
        int p;
        int budget;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed scan on the reset settings
        add_row(1'b0, 32'd5, ROW_SILENT, '0);
        add_row(1'b1, 32'h7fff_ffff, ROW_TYPED, '0);
        add_row(1'b0, 32'h8000_0000, ROW_TYPED, {1'b1, 32'd0, 32'd4096, 11'd1, 1'b0, 1'b0});
        add_row(1'b0, -32'sd1, ROW_PREDICT, '0);
        add_row(1'b0, 32'd0, ROW_PREDICT, '0);
        add_row(1'b0, 32'd0, ROW_PREDICT, '0);
        add_row(1'b0, 32'd1, ROW_PREDICT, '0);
        add_row(1'b0, -32'sd1, ROW_PREDICT, '0);
        add_row(1'b0, 32'd1, ROW_PREDICT, '0);
        add_row(1'b0, 32'd1000, ROW_PREDICT, '0);
        add_row(1'b0, -32'sd1000, ROW_PREDICT, '0);
        add_row(1'b0, 32'h7fff_ffff, ROW_PREDICT, '0);
        add_row(1'b0, 32'h8000_0000, ROW_PREDICT, '0);
        add_row(1'b0, 32'd2, ROW_PREDICT, '0);
        add_row(1'b0, 32'd2, ROW_PREDICT, '0);
        add_row(1'b0, -32'sd3, ROW_PREDICT, '0);
        add_row(1'b0, 32'd0, ROW_PREDICT, '0);
        add_row(1'b0, 32'd5, ROW_PREDICT, '0);
        add_row(1'b0, 32'd7, ROW_SILENT, '0);
        add_row(1'b1, 32'd0, ROW_TYPED, '0);
        add_row(1'b0, 32'd0, ROW_PREDICT, '0);
        foreach (dir_rows[i])
            send_sample(dir_rows[i].rs, dir_rows[i].val, dir_rows[i].kind, dir_rows[i].want);
        drain_results();

        // random phases, each with its own register settings
        p = 0;
        while (n_sent < 750) begin
            calm = ($urandom_range(0, 4) == 0);
            setup_phase(p);
            if (p == 5) begin
                send_sample(1'b1, make_value(), ROW_PREDICT, '0);
                repeat (3) send_sample(1'b0, make_value(), ROW_PREDICT, '0);
                drain_results();
                write_reg(REG_SCAN_END, 32'd4096);
                send_sample(1'b0, make_value(), ROW_PREDICT, '0);
            end
            budget = n_sent + $urandom_range(20, 50);
            while (n_sent < budget && n_sent < 750) begin
                if ($urandom_range(0, 29) == 0)
                    drain_results();
                run_scan();
            end
            drain_results();
            p++;
            n_phases++;
        end
        calm = 1'b0;
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("%0d register phases, %0d samples sent, %0d with a result, %0d intervals",
                 n_phases, n_sent, n_live, n_reports);
        $display("%0d finished-scan beats, %0d capacity stops", n_finished, n_full);
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/scis_pkg.sv
hw/rtl/sign_change_interval_scanner_top.sv
sim/sign_change_interval_scanner_top_tb.sv
